FILE: sv/assert_macros.svh
// Assertion macros for files that check their own logic (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/bbc_pkg.sv
// Types, codes and the keyword matcher shared by the bracket checker modules.
package bbc_pkg;

  // Opener and closer types held on the stack
  typedef logic [1:0] type_t;
  localparam type_t TYPE_PAREN  = 2'd0;
  localparam type_t TYPE_BRACE  = 2'd1;
  localparam type_t TYPE_SQUARE = 2'd2;
  localparam type_t TYPE_BEGIN  = 2'd3;

  // Stack operation codes
  typedef logic [1:0] op_kind_t;
  localparam op_kind_t OP_NONE = 2'd0;
  localparam op_kind_t OP_PUSH = 2'd1;
  localparam op_kind_t OP_POP  = 2'd2;

  // One classified byte, as passed from front to back
  typedef struct packed {
    op_kind_t kind;
    type_t    typ;
    logic     last;
  } op_t;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Keyword match positions
  typedef logic [3:0] pos_t;
  localparam pos_t POS_NONE  = 4'd0;
  localparam pos_t POS_B     = 4'd1;
  localparam pos_t POS_BE    = 4'd2;
  localparam pos_t POS_BEG   = 4'd3;
  localparam pos_t POS_BEGI  = 4'd4;
  localparam pos_t POS_BEGIN = 4'd5;
  localparam pos_t POS_E     = 4'd6;
  localparam pos_t POS_EN    = 4'd7;
  localparam pos_t POS_END   = 4'd8;
  localparam pos_t POS_PLAIN = 4'd9;

  // Characters of interest
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Advance the keyword match by one word byte
  function automatic pos_t next_position(input pos_t pos, input logic [7:0] c);
    pos_t p;
    p = POS_PLAIN;
    case (pos)
      POS_NONE: begin
        if (c == CH_B) p = POS_B;
        else if (c == CH_E) p = POS_E;
      end
      POS_B:    if (c == CH_E) p = POS_BE;
      POS_BE:   if (c == CH_G) p = POS_BEG;
      POS_BEG:  if (c == CH_I) p = POS_BEGI;
      POS_BEGI: if (c == CH_N) p = POS_BEGIN;
      POS_E:    if (c == CH_N) p = POS_EN;
      POS_EN:   if (c == CH_D) p = POS_END;
      default:  p = POS_PLAIN;
    endcase
    next_position = p;
  endfunction

endpackage

FILE: sv/bbc_front.sv
// Front end: accepts text bytes, tracks keyword words and classifies stack operations.
module bbc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           text_valid,
  output logic           text_ready,
  input  logic [7:0]     text_byte,
  input  logic           end_of_text,
  input  logic           q_full,
  output logic           enq,
  output bbc_pkg::op_t   op
);
  import bbc_pkg::*;

  pos_t pos;
  pos_t pos_next;
  pos_t pnext;
  pos_t p_eff;
  logic is_sp;
  logic word_end;

  assign text_ready = !q_full;
  assign enq        = text_valid && text_ready;

  // Classify the byte into at most one push or pop
  always_comb begin
    is_sp    = is_space(text_byte);
    pnext    = next_position(pos, text_byte);
    p_eff    = is_sp ? pos : pnext;
    word_end = is_sp || end_of_text;
    op.kind  = OP_NONE;
    op.typ   = TYPE_PAREN;
    op.last  = end_of_text;
    case (text_byte)
      CH_LPAREN:  begin op.kind = OP_PUSH; op.typ = TYPE_PAREN;  end
      CH_LBRACE:  begin op.kind = OP_PUSH; op.typ = TYPE_BRACE;  end
      CH_LSQUARE: begin op.kind = OP_PUSH; op.typ = TYPE_SQUARE; end
      CH_RPAREN:  begin op.kind = OP_POP;  op.typ = TYPE_PAREN;  end
      CH_RBRACE:  begin op.kind = OP_POP;  op.typ = TYPE_BRACE;  end
      CH_RSQUARE: begin op.kind = OP_POP;  op.typ = TYPE_SQUARE; end
      default: begin
        // A finished keyword word pushes or pops a begin
        if (word_end && (p_eff == POS_BEGIN)) begin
          op.kind = OP_PUSH;
          op.typ  = TYPE_BEGIN;
        end else if (word_end && (p_eff == POS_END)) begin
          op.kind = OP_POP;
          op.typ  = TYPE_BEGIN;
        end
      end
    endcase
    pos_next = word_end ? POS_NONE : pnext;
  end

  // Advance the word match on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_NONE;
    end else if (enq) begin
      pos <= pos_next;
    end
  end

endmodule

FILE: sv/bbc_queue.sv
// Short queue of classified operations between front and back.
module bbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           enq,
  input  bbc_pkg::op_t   enq_op,
  output logic           full,
  input  logic           deq,
  output logic           q_valid,
  output bbc_pkg::op_t   q_op
);
  import bbc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = slots[rd_ptr];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_op;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (enq && !deq) begin
        count <= count + CNT_W'(1);
      end else if (deq && !enq) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/bbc_back.sv
// Back end: runs stack operations and registers the verdict beat.
module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bbc_pkg::op_t   q_op,
  output logic           deq,
  output logic           verdict_valid,
  input  logic           verdict_ready,
  output logic           balanced,
  output logic           stack_overflow
);
  import bbc_pkg::*;

  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // Entries below the top; the top itself sits in a register
  type_t             type_mem [STACK_DEPTH];
  type_t             top;
  type_t             top_next;
  type_t             rd_data;
  type_t             byp_data;
  type_t             second;
  logic              byp_valid;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  level_next;
  logic              mismatch;
  logic              mismatch_next;
  logic              overflow;
  logic              overflow_next;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              slot_free;

  // Second entry from memory, or the value written in the last cycle
  assign second    = byp_valid ? byp_data : rd_data;
  assign slot_free = !verdict_valid || verdict_ready;
  assign deq       = q_valid && (!q_op.last || slot_free);

  // Work out the stack update for the dequeued operation
  always_comb begin
    level_next    = level;
    top_next      = top;
    mismatch_next = mismatch;
    overflow_next = overflow;
    wr_en         = 1'b0;
    wr_addr       = ADDR_W'(level - LVL_W'(1));
    if (deq) begin
      case (q_op.kind)
        OP_PUSH: begin
          if (level >= LVL_W'(STACK_DEPTH)) begin
            overflow_next = 1'b1;
          end else begin
            wr_en      = (level != '0);
            level_next = level + LVL_W'(1);
            top_next   = q_op.typ;
          end
        end
        OP_POP: begin
          if (level == '0) begin
            mismatch_next = 1'b1;
          end else begin
            if (top != q_op.typ) mismatch_next = 1'b1;
            level_next = level - LVL_W'(1);
            top_next   = second;
          end
        end
        default: begin
        end
      endcase
    end
    rd_addr = (level_next >= LVL_W'(2)) ? ADDR_W'(level_next - LVL_W'(2)) : '0;
  end

  // Write the old top on a push and prefetch the entry below the new top
  always_ff @(posedge clk) begin
    if (wr_en) begin
      type_mem[wr_addr] <= top;
    end
    rd_data  <= type_mem[rd_addr];
    byp_data <= top;
    top      <= top_next;
  end

  // Update level and sticky flags; clear them after the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      mismatch  <= 1'b0;
      overflow  <= 1'b0;
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= wr_en && (wr_addr == rd_addr);
      if (deq && q_op.last) begin
        level    <= '0;
        mismatch <= 1'b0;
        overflow <= 1'b0;
      end else begin
        level    <= level_next;
        mismatch <= mismatch_next;
        overflow <= overflow_next;
      end
    end
  end

  // Hold the verdict beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (deq && q_op.last) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deq && q_op.last) begin
      balanced       <= !mismatch_next && !overflow_next && (level_next == '0);
      stack_overflow <= overflow_next;
    end
  end

endmodule

FILE: sv/bracket_balance_checker.sv
// Top level of the bracket and begin/end balance checker.
// Usage:
//   The text channel takes one byte per beat (text_byte) with end_of_text
//   marking the final byte of a text. Words are split at whitespace; a word
//   that is exactly begin or end opens or closes a block, and in other words
//   each ( ) { } [ ] opens or closes a bracket of its kind.
//   The verdict channel gives one beat per text, on its final byte:
//   balanced is 1 when every closer matched, nothing is left open and the
//   stack never overflowed; stack_overflow is 1 when nesting went past
//   STACK_DEPTH at some point.
//   Throughput: one byte per cycle while the verdict receiver does not stall,
//   set by one stack push or pop per cycle in the back end, with the stack
//   top held in a register and the entry below it prefetched from the stack
//   memory. The final byte is written into the queue and, once dequeued,
//   sets the verdict register that drives the verdict beat.
//   Reset clears the word tracker, stack level, flags and queue. After each
//   verdict the block starts a new text at once.
//   When the verdict receiver stalls, bytes keep flowing until a second
//   final byte reaches the back end; then the two-entry queue fills and
//   text_ready drops.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       verdict_valid,
  input  logic       verdict_ready,
  output logic       balanced,
  output logic       stack_overflow
);
  import bbc_pkg::*;

  `include "assert_macros.svh"

  logic enq;
  logic q_full;
  logic q_valid;
  logic deq;
  op_t  enq_op;
  op_t  q_op;

  // Classify bytes into stack operations
  bbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .enq         (enq),
    .op          (enq_op)
  );

  // Decouple front and back
  bbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_op  (enq_op),
    .full    (q_full),
    .deq     (deq),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  // Run the stack and give the verdict
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .deq            (deq),
    .verdict_valid  (verdict_valid),
    .verdict_ready  (verdict_ready),
    .balanced       (balanced),
    .stack_overflow (stack_overflow)
  );

  // Checks on the internal hand-off and the verdict
  `ASSERT_IMPLIES(a_deq_only_valid, deq, q_valid, "queue read while empty")
  `ASSERT_IMPLIES(a_verdict_src, $rose(verdict_valid), $past(deq && q_op.last), "stray verdict")
  `ASSERT_ALWAYS(a_ovf_unbal, !(verdict_valid && balanced && stack_overflow), "overflow verdict")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the bracket and begin/end balance checker.
`timescale 1ns / 100ps

module testbench;
  import bbc_pkg::*;

  localparam int NEST_DEPTH = 64;
  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  // One verdict beat
  typedef struct packed {
    logic balanced;
    logic overflow;
  } verdict_t;

  localparam verdict_t V_OK  = '{1'b1, 1'b0};
  localparam verdict_t V_BAD = '{1'b0, 1'b0};

  // One row of the directed table
  typedef struct {
    logic [7:0] b;
    logic       eot;
    bit         typed;
    verdict_t   v;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_ready;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       verdict_valid;
  logic       verdict_ready = 1'b0;
  logic       balanced;
  logic       stack_overflow;

  bracket_balance_checker #(
    .STACK_DEPTH(NEST_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .balanced      (balanced),
    .stack_overflow(stack_overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow state of the nesting tracker
  type_t       nest_types[NEST_DEPTH];
  int unsigned nest_level;
  pos_t        word_pos;
  bit          word_plain;
  bit          close_err;
  bit          overflow_hit;

  verdict_t    verdicts_due[$];
  logic [7:0]  text_buf[$];
  int          bytes_sent;
  int          mismatches;
  int          cycles;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_stall_left;
  verdict_t    head;

  string near_words[16] = '{"begin", "end", "begi", "Begin", "beginn", "bend", "en", "endd",
                            "e", "b", "xend", "ebegin", "begin(", "end]", "(begin", "END"};

  function automatic bit blank_byte(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Step the keyword match by one word byte
  function automatic pos_t match_step(input pos_t pos, input logic [7:0] c);
    logic [7:0] want;
    want = 8'h00;
    case (pos)
      POS_NONE: begin
        if (c == CH_B) return POS_B;
        if (c == CH_E) return POS_E;
        return POS_PLAIN;
      end
      POS_B:    want = CH_E;
      POS_BE:   want = CH_G;
      POS_BEG:  want = CH_I;
      POS_BEGI: want = CH_N;
      POS_E:    want = CH_N;
      POS_EN:   want = CH_D;
      default:  want = 8'h00;
    endcase
    if (want != 8'h00 && c == want) return pos_t'(pos + 4'd1);
    return POS_PLAIN;
  endfunction

  function automatic void open_nest(input type_t t);
    if (nest_level >= NEST_DEPTH) begin
      overflow_hit = 1'b1;
    end else begin
      nest_types[nest_level] = t;
      nest_level++;
    end
  endfunction

  function automatic void close_nest(input type_t t);
    if (nest_level == 0) begin
      close_err = 1'b1;
    end else begin
      nest_level--;
      if (nest_types[nest_level] != t) close_err = 1'b1;
    end
  endfunction

  // Turn a finished keyword into a push or a pop
  function automatic void finish_word();
    if (!word_plain) begin
      if (word_pos == POS_BEGIN) open_nest(TYPE_BEGIN);
      else if (word_pos == POS_END) close_nest(TYPE_BEGIN);
    end
    word_pos = POS_NONE;
    word_plain = 1'b0;
  endfunction

  function automatic void clear_text();
    foreach (nest_types[i]) nest_types[i] = TYPE_PAREN;
    nest_level = 0;
    word_pos = POS_NONE;
    word_plain = 1'b0;
    close_err = 1'b0;
    overflow_hit = 1'b0;
  endfunction

  // Advance the shadow state by one byte; return 1 when a verdict is due
  function automatic bit predict_byte(input logic [7:0] c, input logic last, output verdict_t v);
    v = V_BAD;
    if (blank_byte(c)) begin
      finish_word();
    end else begin
      if (!word_plain) begin
        word_pos = match_step(word_pos, c);
        if (word_pos == POS_PLAIN) word_plain = 1'b1;
      end
      case (c)
        CH_LPAREN:  open_nest(TYPE_PAREN);
        CH_LBRACE:  open_nest(TYPE_BRACE);
        CH_LSQUARE: open_nest(TYPE_SQUARE);
        CH_RPAREN:  close_nest(TYPE_PAREN);
        CH_RBRACE:  close_nest(TYPE_BRACE);
        CH_RSQUARE: close_nest(TYPE_SQUARE);
        default: ;
      endcase
    end
    if (!last) return 1'b0;
    finish_word();
    v.balanced = !close_err && !overflow_hit && nest_level == 0;
    v.overflow = overflow_hit;
    clear_text();
    return 1'b1;
  endfunction

  function automatic logic [7:0] open_char(input type_t t);
    case (t)
      TYPE_PAREN: return CH_LPAREN;
      TYPE_BRACE: return CH_LBRACE;
      default:    return CH_LSQUARE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input type_t t);
    case (t)
      TYPE_PAREN: return CH_RPAREN;
      TYPE_BRACE: return CH_RBRACE;
      default:    return CH_RSQUARE;
    endcase
  endfunction

  // Append one byte to the text under construction
  function automatic void append_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  function automatic void add_blank();
    int k;
    k = $urandom_range(0, 5);
    append_byte(k == 5 ? CH_SPACE : CH_TAB + 8'(k));
  endfunction

  // Keep a keyword a word of its own
  function automatic void add_word(input string s);
    if (text_buf.size() != 0 && !blank_byte(text_buf[$])) add_blank();
    for (int i = 0; i < s.len(); i++) append_byte(8'(s[i]));
    add_blank();
  endfunction

  function automatic void add_opener(input type_t t);
    if (t == TYPE_BEGIN) begin
      add_word("begin");
    end else begin
      if ($urandom_range(0, 3) == 0) append_byte(8'($urandom_range(8'h61, 8'h7A)));
      append_byte(open_char(t));
      if ($urandom_range(0, 1) == 1) add_blank();
    end
  endfunction

  function automatic void add_closer(input type_t t);
    if (t == TYPE_BEGIN) begin
      add_word("end");
    end else begin
      append_byte(close_char(t));
      if ($urandom_range(0, 1) == 1) add_blank();
    end
  endfunction

  function automatic void add_filler();
    int n;
    int pick;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) append_byte(8'($urandom_range(8'h61, 8'h7A)));
      else if (pick < 8) append_byte(8'($urandom_range(8'h30, 8'h3B)));
      else append_byte(8'($urandom_range(8'h80, 8'hFF)));
    end
    if ($urandom_range(0, 1) == 1) add_blank();
  endfunction

  // Build a nested text, optionally with one fault: left open, stray closer, wrong closer
  function automatic void build_nested(input int depth_cap, input int tokens, input bit faulty);
    type_t open_kinds[$];
    type_t t;
    int    fault_at;
    int    fault_kind;
    int    pick;
    fault_at = faulty ? $urandom_range(0, tokens - 1) : -1;
    fault_kind = $urandom_range(0, 2);
    for (int i = 0; i < tokens; i++) begin
      if (i == fault_at && fault_kind == 1) begin
        add_closer(type_t'($urandom_range(0, 3)));
      end else if (i == fault_at && fault_kind == 2 && open_kinds.size() != 0) begin
        t = open_kinds.pop_back();
        add_closer(t ^ type_t'($urandom_range(1, 3)));
      end
      pick = $urandom_range(0, 9);
      if (pick < 4 && open_kinds.size() < depth_cap) begin
        t = type_t'($urandom_range(0, 3));
        add_opener(t);
        open_kinds.insert(open_kinds.size(), t);
      end else if (pick < 8 && open_kinds.size() != 0) begin
        add_closer(open_kinds.pop_back());
      end else begin
        add_filler();
      end
    end
    if (faulty && fault_kind == 0) begin
      if (open_kinds.size() != 0) void'(open_kinds.pop_front());
      else add_opener(type_t'($urandom_range(0, 3)));
    end
    while (open_kinds.size() != 0) add_closer(open_kinds.pop_back());
  endfunction

  // Build a run of bare brackets around the stack depth
  function automatic void build_deep(input int depth);
    type_t open_kinds[$];
    type_t t;
    for (int i = 0; i < depth; i++) begin
      t = type_t'($urandom_range(0, 2));
      append_byte(open_char(t));
      open_kinds.insert(open_kinds.size(), t);
    end
    while (open_kinds.size() != 0) append_byte(close_char(open_kinds.pop_back()));
  endfunction

  // Build a line of keyword look-alikes
  function automatic void build_keywords();
    int n;
    string s;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      s = near_words[$urandom_range(0, 15)];
      for (int j = 0; j < s.len(); j++) append_byte(8'(s[j]));
      if (i != n - 1 || $urandom_range(0, 1) == 1) add_blank();
    end
  endfunction

  function automatic void build_noise();
    int n;
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) append_byte(8'($urandom_range(0, 255)));
  endfunction

  // Drive one beat on the text channel, with a random gap in front
  task automatic drive_byte(input logic [7:0] b, input logic eot, input bit typed,
                            input verdict_t typed_v);
    verdict_t v;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    if (predict_byte(b, eot, v))
      verdicts_due.insert(verdicts_due.size(), typed ? typed_v : v);
    text_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!text_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    if (text_buf.size() == 0) add_blank();
    foreach (text_buf[i]) drive_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, V_BAD);
  endtask

  task automatic hold_until_drained();
    text_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
  endtask

  stim_row_t stim_table[23] = '{
    '{8'h00,      1'b1, 1'b1, V_OK},
    '{8'hFF,      1'b1, 1'b1, V_OK},
    '{CH_RPAREN,  1'b1, 1'b1, V_BAD},
    '{CH_LPAREN,  1'b1, 1'b1, V_BAD},
    '{CH_LSQUARE, 1'b0, 1'b0, V_BAD},
    '{CH_RBRACE,  1'b1, 1'b1, V_BAD},
    '{CH_LBRACE,  1'b0, 1'b0, V_BAD},
    '{CH_RBRACE,  1'b1, 1'b1, V_OK},
    '{CH_B,       1'b0, 1'b0, V_BAD},
    '{CH_E,       1'b0, 1'b0, V_BAD},
    '{CH_G,       1'b0, 1'b0, V_BAD},
    '{CH_I,       1'b0, 1'b0, V_BAD},
    '{CH_N,       1'b0, 1'b0, V_BAD},
    '{8'h0A,      1'b0, 1'b0, V_BAD},
    '{CH_E,       1'b0, 1'b0, V_BAD},
    '{CH_N,       1'b0, 1'b0, V_BAD},
    '{CH_D,       1'b1, 1'b1, V_OK},
    '{CH_E,       1'b0, 1'b0, V_BAD},
    '{CH_N,       1'b0, 1'b0, V_BAD},
    '{CH_D,       1'b1, 1'b1, V_BAD},
    '{8'h0C,      1'b1, 1'b1, V_OK},
    '{8'h80,      1'b0, 1'b0, V_BAD},
    '{CH_RSQUARE, 1'b1, 1'b1, V_BAD}
  };

  // Stall the verdict channel in random bursts
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      verdict_ready <= 1'b0;
    end else if (!rst && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall_left = $urandom_range(0, 4);
      verdict_ready <= 1'b0;
    end else begin
      verdict_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string field, input logic want, input logic got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch at cycle %0d: %s expected %b, got %b", cycles, field, want, got);
  endtask

  // Check each verdict beat against the oldest expectation; bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("bracket_balance_checker regression: fail");
      $finish;
    end
    if (!rst && verdict_valid && verdict_ready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch at cycle %0d: verdict beat with none expected", cycles);
      end else begin
        head = verdicts_due.pop_front();
        if (balanced !== head.balanced) report_mismatch("balanced", head.balanced, balanced);
        if (stack_overflow !== head.overflow)
          report_mismatch("stack_overflow", head.overflow, stack_overflow);
      end
    end
  end

  initial begin
    int  kind;
    bit  paused;
    clear_text();
    bytes_sent = 0;
    mismatches = 0;
    cycles = 0;
    rx_stall_left = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    paused = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (stim_table[i])
      drive_byte(stim_table[i].b, stim_table[i].eot, stim_table[i].typed, stim_table[i].v);

    // Fill the stack exactly, then go one past it
    text_buf.delete();
    build_deep(NEST_DEPTH);
    send_text();
    text_buf.delete();
    build_deep(NEST_DEPTH + 1);
    send_text();

    // Random texts, mostly nested structures
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent < 400) begin
        tx_idle_pct = 25;
        rx_idle_pct = 30;
      end else if (bytes_sent < 700) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (bytes_sent < 1300) begin
        tx_idle_pct = 10;
        rx_idle_pct = 50;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (!paused && bytes_sent >= 700) begin
        hold_until_drained();
        paused = 1'b1;
      end
      text_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 55) build_nested($urandom_range(1, 8), $urandom_range(2, 14),
                                  $urandom_range(0, 99) < 30);
      else if (kind < 72) build_keywords();
      else if (kind < 97) build_noise();
      else build_deep($urandom_range(62, 68));
      send_text();
    end

    // Drain and finish
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("bracket_balance_checker regression: pass");
    else $display("bracket_balance_checker regression: fail");
    $finish;
  end

endmodule
